/* src/qte_pkg.sv */
// Shared types, widths and the arctangent table for the quaternion to
// Euler angle pipeline. No dependencies.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int CORDIC_STEPS = 16;      // legal range 8 to 24
    localparam int ATAN_LEN     = 24;
    localparam int SUM_W        = 34;      // Q3.30 sums
    localparam int CORD_W       = 36;      // CORDIC x/y datapath
    localparam int ANG_W        = 34;      // angle, 2^32 = 2*pi
    localparam int RAD_W        = 62;      // square root radicand
    localparam int ROOT_W       = 31;
    localparam int SQRT_STEPS   = 31;      // one result bit per stage
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    typedef logic signed [15:0] q15_t;

    typedef struct packed {
        q15_t quat_w;
        q15_t quat_x;
        q15_t quat_y;
        q15_t quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] angle_first;
        logic signed [15:0] angle_middle;
        logic signed [15:0] angle_last;
        logic               asin_clamped;
    } euler_t;

    // atan(2^-i), 2^32 = 2*pi
    function automatic logic signed [ANG_W-1:0] atan_lut(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* src/qte_if.sv */
// Valid/ready channel interfaces for quaternion words and angle words.
// Depends on qte_pkg.
`timescale 1ns / 1ps

interface quat_if import qte_pkg::*; ();
    logic  valid;
    logic  ready;
    quat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface euler_if import qte_pkg::*; ();
    logic   valid;
    logic   ready;
    euler_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/quaternion_to_euler_angles.sv */
// Quaternion (Q1.15) to three Euler angles as 16-bit binary angles.
// Throughput one word per cycle while the output is not stalled, set by a
// fully pipelined square root and three CORDIC pipelines. A stalled output
// freezes every stage. rst_n clears all valid bits.
`timescale 1ns / 1ps

module quaternion_to_euler_angles import qte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    quat_if.sink         quat,
    euler_if.source      euler
);

    localparam int TAIL_LEN = SQRT_STEPS + CORDIC_LAT;
    localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(1) << 30;
    localparam logic [RAD_W-1:0] ONE_Q60 = RAD_W'(1) << 60;

    logic adv;

    // stage valid bits
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v_tail_reg [TAIL_LEN];

    // stage 0: input word
    quat_t q_reg;
    // stage 1: products
    logic signed [31:0] p_wz_reg, p_xy_reg, p_zz_reg, p_xx_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_yy_reg, p_wx_reg, p_yz_reg;
    // stage 2: sums
    logic signed [SUM_W-1:0] num1_reg, den1_reg, num3_reg, den3_reg, t_reg;
    // stage 3..5
    logic signed [SUM_W-1:0] num1_3_reg, den1_3_reg, num3_3_reg, den3_3_reg, tc3_reg;
    logic signed [SUM_W-1:0] num1_4_reg, den1_4_reg, num3_4_reg, den3_4_reg, tc4_reg;
    logic signed [SUM_W-1:0] num1_5_reg, den1_5_reg, num3_5_reg, den3_5_reg, tc5_reg;
    logic [ROOT_W-1:0] tm_reg;
    logic clamp3_reg, clamp4_reg, clamp5_reg;
    logic [31:0] aa_reg, ab_reg, bb_reg;
    logic [RAD_W-1:0] rad_reg;

    // side data riding along the square root
    logic signed [SUM_W-1:0] num1_d_reg [SQRT_STEPS];
    logic signed [SUM_W-1:0] den1_d_reg [SQRT_STEPS];
    logic signed [SUM_W-1:0] num3_d_reg [SQRT_STEPS];
    logic signed [SUM_W-1:0] den3_d_reg [SQRT_STEPS];
    logic signed [SUM_W-1:0] tc_d_reg   [SQRT_STEPS];
    logic                    clamp_d_reg [TAIL_LEN];

    logic signed [SUM_W-1:0] t_sum;
    logic signed [SUM_W-1:0] tc_next;
    logic                    clamp_next;
    logic signed [SUM_W-1:0] tabs;
    logic [RAD_W-1:0]        tmsq;
    logic [ROOT_W-1:0]       root;
    logic signed [SUM_W-1:0] root_ext;
    logic signed [15:0]      ang1, ang2, ang3;

    assign adv        = !v_tail_reg[TAIL_LEN-1] || euler.ready;
    assign quat.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int k = 0; k < TAIL_LEN; k++)
            begin
                v_tail_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg <= quat.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v_tail_reg[0] <= v5_reg;
            for (int k = 1; k < TAIL_LEN; k++)
            begin
                v_tail_reg[k] <= v_tail_reg[k-1];
            end
        end
    end

    // clamp the asin argument to [-1, 1]
    always_comb
    begin
        t_sum      = t_reg;
        tc_next    = t_sum;
        clamp_next = 1'b0;
        if (t_sum > ONE_Q30)
        begin
            tc_next    = ONE_Q30;
            clamp_next = 1'b1;
        end
        else if (t_sum < -ONE_Q30)
        begin
            tc_next    = -ONE_Q30;
            clamp_next = 1'b1;
        end
        tabs = tc_next[SUM_W-1] ? -tc_next : tc_next;
    end

    assign tmsq = (RAD_W'(aa_reg) << 30) + (RAD_W'(ab_reg) << 15) + RAD_W'(bb_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= quat.data;

            p_wz_reg <= q_reg.quat_w * q_reg.quat_z;
            p_xy_reg <= q_reg.quat_x * q_reg.quat_y;
            p_zz_reg <= q_reg.quat_z * q_reg.quat_z;
            p_xx_reg <= q_reg.quat_x * q_reg.quat_x;
            p_wy_reg <= q_reg.quat_w * q_reg.quat_y;
            p_zx_reg <= q_reg.quat_z * q_reg.quat_x;
            p_yy_reg <= q_reg.quat_y * q_reg.quat_y;
            p_wx_reg <= q_reg.quat_w * q_reg.quat_x;
            p_yz_reg <= q_reg.quat_y * q_reg.quat_z;

            // sums never leave Q3.30 for Q1.15 operands
            num1_reg <= (SUM_W'(p_wz_reg) + SUM_W'(p_xy_reg)) <<< 1;
            den1_reg <= ONE_Q30 - ((SUM_W'(p_zz_reg) + SUM_W'(p_xx_reg)) <<< 1);
            num3_reg <= (SUM_W'(p_wy_reg) + SUM_W'(p_zx_reg)) <<< 1;
            den3_reg <= ONE_Q30 - ((SUM_W'(p_xx_reg) + SUM_W'(p_yy_reg)) <<< 1);
            t_reg    <= (SUM_W'(p_wx_reg) - SUM_W'(p_yz_reg)) <<< 1;

            num1_3_reg <= num1_reg;
            den1_3_reg <= den1_reg;
            num3_3_reg <= num3_reg;
            den3_3_reg <= den3_reg;
            tc3_reg    <= tc_next;
            clamp3_reg <= clamp_next;
            tm_reg     <= tabs[ROOT_W-1:0];

            // split the square into three narrow products
            num1_4_reg <= num1_3_reg;
            den1_4_reg <= den1_3_reg;
            num3_4_reg <= num3_3_reg;
            den3_4_reg <= den3_3_reg;
            tc4_reg    <= tc3_reg;
            clamp4_reg <= clamp3_reg;
            aa_reg     <= 32'(tm_reg[30:15]) * 32'(tm_reg[30:15]);
            ab_reg     <= (32'(tm_reg[30:15]) * 32'(tm_reg[14:0])) << 1;
            bb_reg     <= 32'(tm_reg[14:0]) * 32'(tm_reg[14:0]);

            num1_5_reg <= num1_4_reg;
            den1_5_reg <= den1_4_reg;
            num3_5_reg <= num3_4_reg;
            den3_5_reg <= den3_4_reg;
            tc5_reg    <= tc4_reg;
            clamp5_reg <= clamp4_reg;
            rad_reg    <= ONE_Q60 - tmsq;

            num1_d_reg[0] <= num1_5_reg;
            den1_d_reg[0] <= den1_5_reg;
            num3_d_reg[0] <= num3_5_reg;
            den3_d_reg[0] <= den3_5_reg;
            tc_d_reg[0]   <= tc5_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                num1_d_reg[k] <= num1_d_reg[k-1];
                den1_d_reg[k] <= den1_d_reg[k-1];
                num3_d_reg[k] <= num3_d_reg[k-1];
                den3_d_reg[k] <= den3_d_reg[k-1];
                tc_d_reg[k]   <= tc_d_reg[k-1];
            end

            clamp_d_reg[0] <= clamp5_reg;
            for (int k = 1; k < TAIL_LEN; k++)
            begin
                clamp_d_reg[k] <= clamp_d_reg[k-1];
            end
        end
    end

    qte_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (rad_reg),
        .root     (root)
    );

    assign root_ext = SUM_W'({1'b0, root});

    qte_cordic u_cordic_first (
        .clk   (clk),
        .en    (adv),
        .num   (num1_d_reg[SQRT_STEPS-1]),
        .den   (den1_d_reg[SQRT_STEPS-1]),
        .angle (ang1)
    );

    qte_cordic u_cordic_middle (
        .clk   (clk),
        .en    (adv),
        .num   (tc_d_reg[SQRT_STEPS-1]),
        .den   (root_ext),
        .angle (ang2)
    );

    qte_cordic u_cordic_last (
        .clk   (clk),
        .en    (adv),
        .num   (num3_d_reg[SQRT_STEPS-1]),
        .den   (den3_d_reg[SQRT_STEPS-1]),
        .angle (ang3)
    );

    assign euler.valid             = v_tail_reg[TAIL_LEN-1];
    assign euler.data.angle_first  = ang1;
    assign euler.data.angle_middle = ang2;
    assign euler.data.angle_last   = ang3;
    assign euler.data.asin_clamped = clamp_d_reg[TAIL_LEN-1];

endmodule

/* src/qte_sqrt.sv */
// Pipelined restoring integer square root, one result bit per stage.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_sqrt import qte_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0] n_reg   [SQRT_STEPS];
    logic [RAD_W-1:0] res_reg [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++) begin : g_step
            localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            logic [RAD_W-1:0] n_cur;
            logic [RAD_W-1:0] res_cur;
            logic [RAD_W-1:0] trial;
            if (k == 0) begin : g_first
                assign n_cur   = radicand;
                assign res_cur = '0;
            end
            else begin : g_rest
                assign n_cur   = n_reg[k-1];
                assign res_cur = res_reg[k-1];
            end
            assign trial = res_cur + BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (n_cur >= trial)
                    begin
                        n_reg[k]   <= n_cur - trial;
                        res_reg[k] <= (res_cur >> 1) + BIT;
                    end
                    else
                    begin
                        n_reg[k]   <= n_cur;
                        res_reg[k] <= res_cur >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = res_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

/* src/qte_cordic.sv */
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation and rounding
// to a 16-bit binary angle. Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_cordic import qte_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SUM_W-1:0] num,
    input  logic signed [SUM_W-1:0] den,
    output logic signed [15:0]      angle
);

    localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(1) << 30;
    localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(32768);

    logic signed [CORD_W-1:0] x_reg   [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] y_reg   [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]  ang_reg [CORDIC_STEPS+1];
    logic                     zero_reg [CORDIC_STEPS+1];
    logic signed [15:0]       angle_reg;

    logic signed [CORD_W-1:0] xe;
    logic signed [CORD_W-1:0] ye;
    logic signed [ANG_W-1:0]  rounded;

    assign xe = CORD_W'(den);
    assign ye = CORD_W'(num);

    // fold the left half plane onto the right
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (num == '0) && (den == '0);
            if (xe < 0)
            begin
                if (ye >= 0)
                begin
                    x_reg[0]   <= ye;
                    y_reg[0]   <= -xe;
                    ang_reg[0] <= QUARTER;
                end
                else
                begin
                    x_reg[0]   <= -ye;
                    y_reg[0]   <= xe;
                    ang_reg[0] <= -QUARTER;
                end
            end
            else
            begin
                x_reg[0]   <= xe;
                y_reg[0]   <= ye;
                ang_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
            localparam logic signed [ANG_W-1:0] ATAN_I = atan_lut(i);
            logic signed [CORD_W-1:0] xs;
            logic signed [CORD_W-1:0] ys;
            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (!y_reg[i][CORD_W-1])
                    begin
                        x_reg[i+1]   <= x_reg[i] + ys;
                        y_reg[i+1]   <= y_reg[i] - xs;
                        ang_reg[i+1] <= ang_reg[i] + ATAN_I;
                    end
                    else
                    begin
                        x_reg[i+1]   <= x_reg[i] - ys;
                        y_reg[i+1]   <= y_reg[i] + xs;
                        ang_reg[i+1] <= ang_reg[i] - ATAN_I;
                    end
                end
            end
        end
    endgenerate

    assign rounded = ang_reg[CORDIC_STEPS] + HALF_LSB;

    // round half up, wrap modulo 2^16
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[CORDIC_STEPS] ? 16'sd0 : rounded[31:16];
        end
    end

    assign angle = angle_reg;

endmodule

/* sim/tb_top.sv */
// Testbench for quaternion_to_euler_angles: drives quaternion words with random
// gaps, predicts the Euler angles with an in-bench CORDIC model and checks each
// result word in order. Depends on qte_pkg, qte_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import qte_pkg::*;

    logic clk;
    logic rst_n;

    quat_if  quat ();
    euler_if euler ();

    quaternion_to_euler_angles uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat),
        .euler (euler)
    );

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam int     LIMIT   = 400000;

    euler_t angles_due[$];
    int     mismatches;
    int     cycles;
    bit     no_idle;
    bit     timed_out;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint sat_q30(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< 33) - 1;
        lo = -(64'sd1 <<< 33);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint int_sqrt(input longint n_in);
        longint n;
        longint res;
        longint b;
        n = n_in;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    // vectoring CORDIC, angle units 2^32 = 2*pi, rounded to a 16-bit angle
    function automatic logic [15:0] binary_atan2(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint t;
        longint ang;
        longint xs;
        longint ys;
        x = x_in;
        y = y_in;
        ang = 0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                ang = ONE_Q30;
            end
            else
            begin
                x = -y;
                y = t;
                ang = -ONE_Q30;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                ang = ang + longint'(atan_lut(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                ang = ang - longint'(atan_lut(i));
            end
        end
        t = (ang + 32768) >>> 16;
        return t[15:0];
    endfunction

    function automatic euler_t predict_angles(input quat_t q);
        longint w;
        longint x;
        longint y;
        longint z;
        longint arg;
        longint mag;
        euler_t e;
        w = q.quat_w;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        e.asin_clamped = 1'b0;
        arg = sat_q30(2 * (w * x - y * z));
        if (arg > ONE_Q30)
        begin
            arg = ONE_Q30;
            e.asin_clamped = 1'b1;
        end
        else if (arg < -ONE_Q30)
        begin
            arg = -ONE_Q30;
            e.asin_clamped = 1'b1;
        end
        mag = (arg < 0) ? -arg : arg;
        e.angle_first  = binary_atan2(sat_q30(2 * (w * z + x * y)),
                                      sat_q30(ONE_Q30 - 2 * (z * z + x * x)));
        e.angle_middle = binary_atan2(arg, int_sqrt((64'sd1 <<< 60) - mag * mag));
        e.angle_last   = binary_atan2(sat_q30(2 * (w * y + z * x)),
                                      sat_q30(ONE_Q30 - 2 * (x * x + y * y)));
        return e;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 31);
    endfunction

    task automatic send_word(input quat_t q);
        while (idle_now())
        begin
            quat.valid <= 1'b0;
            @(negedge clk);
        end
        quat.valid <= 1'b1;
        quat.data  <= q;
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
        angles_due.push_back(predict_angles(q));
        @(negedge clk);
    endtask

    task automatic send_components(input int w, input int x, input int y, input int z);
        quat_t q;
        q.quat_w = w[15:0];
        q.quat_x = x[15:0];
        q.quat_y = y[15:0];
        q.quat_z = z[15:0];
        send_word(q);
    endtask

    // near-unit quaternion: pick a direction, scale so the norm is about one
    function automatic quat_t unit_quat();
        real c[4];
        real n;
        quat_t q;
        n = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = real'(int'($urandom_range(65535)) - 32768);
            n = n + c[i] * c[i];
        end
        if (n == 0.0)
            n = 1.0;
        n = $sqrt(n);
        q.quat_w = 16'(int'($floor(c[0] / n * 32767.0)));
        q.quat_x = 16'(int'($floor(c[1] / n * 32767.0)));
        q.quat_y = 16'(int'($floor(c[2] / n * 32767.0)));
        q.quat_z = 16'(int'($floor(c[3] / n * 32767.0)));
        return q;
    endfunction

    task automatic test_extremes();
        send_components(32767, 0, 0, 0);
        send_components(-32768, 0, 0, 0);
        send_components(0, 0, 0, 0);
        send_components(0, 32767, 0, 0);
        send_components(0, 0, 32767, 0);
        send_components(0, 0, 0, 32767);
        send_components(-32768, -32768, -32768, -32768);
        send_components(32767, 32767, 32767, 32767);
        send_components(-32768, 32767, -32768, 32767);
        send_components(0, 0, 0, -32768);
    endtask

    // gimbal lock: 2(wx-yz) at, just under and beyond one
    task automatic test_asin_limits();
        send_components(23170, 23170, 0, 0);
        send_components(23170, -23170, 0, 0);
        send_components(23171, 23171, 0, 0);
        send_components(-23171, 23171, 0, 0);
        send_components(16384, 16384, -16384, 16384);
        send_components(16384, 16384, 16384, -16384);
        send_components(0, 0, 23170, -23170);
        send_components(32767, 32767, 0, 0);
    endtask

    // negative denominators with zero and negative numerators
    task automatic test_quadrants();
        send_components(0, 23170, 0, 23170);
        send_components(0, 32767, 0, -1);
        send_components(0, 32767, 1, 0);
        send_components(1, 0, 0, -32768);
        send_components(-1, 0, 0, 32767);
        send_components(0, 0, 32767, 1);
    endtask

    task automatic test_random_words();
        quat_t q;
        for (int i = 0; i < 800; i++)
        begin
            no_idle = (i >= 300 && i < 400);
            if ($urandom_range(99) < 75)
                q = unit_quat();
            else
                q = quat_t'({$urandom, $urandom});
            send_word(q);
        end
        no_idle = 1'b0;
    endtask

    // result checker and output stall
    always @(posedge clk)
    begin
        if (rst_n && euler.valid && euler.ready)
        begin
            if (angles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", euler.data);
            end
            else
            begin
                if (euler.data !== angles_due[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", angles_due[0], euler.data);
                end
                void'(angles_due.pop_front());
            end
        end
    end

    always @(negedge clk)
        euler.ready <= !idle_now();

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        no_idle = 1'b0;
        timed_out = 1'b0;
        rst_n = 1'b0;
        quat.valid = 1'b0;
        quat.data = '0;
        euler.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_asin_limits();
        test_quadrants();
        test_random_words();
        quat.valid <= 1'b0;
        while (angles_due.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
